### rtl/posl_pkg.sv
// Shared types and codes for the positional ordered list.
package posl_pkg;

   localparam int DATA_W           = 32;
   localparam int POS_W            = 5;
   localparam int LEN_W            = 5;
   localparam int DEFAULT_CAPACITY = 16;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]               func;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] read_data;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

### rtl/posl_cell.sv
// One list slot: holds, takes its lower neighbor, its upper neighbor or the new value.
module posl_cell #(
   parameter int IDX   = 0,
   parameter int CMP_W = 5
) (
   input  logic                              clock,
   input  posl_pkg::cell_cmd_type            cmd,
   input  logic signed [posl_pkg::DATA_W-1:0] left_q,
   input  logic signed [posl_pkg::DATA_W-1:0] right_q,
   output logic signed [posl_pkg::DATA_W-1:0] entry_q
);
   import posl_pkg::*;

   localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);

   logic [CMP_W-1:0]         pos_cmp;
   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   assign pos_cmp = CMP_W'(cmd.pos);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         // shift up above the insert point
         if (IDX_C > pos_cmp) begin
            entry_in = left_q;
         end else if (IDX_C == pos_cmp) begin
            entry_in = cmd.value;
         end
      end else if (cmd.rem) begin
         if (IDX_C >= pos_cmp) begin
            entry_in = right_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

### rtl/positional_ordered_list.sv
// Top level of the positional ordered list: control, length count, cell row, result register.
//
//   channel | direction | payload            | handshake
//   req_    | in        | posl_pkg::req_type | req_valid / req_stall
//   rsp_    | out       | posl_pkg::rsp_type | rsp_valid / rsp_stall
//
// One request per cycle while no held result stalls req_: every cell shifts or holds in the
// accepting cycle, and the result shows on rsp_ in the cycle after the request transfer.
// The read path is one multiplexer over at most the first 32 cells (position is 5 bits).
// Reset clears the length and the result valid flag; cell contents are left as they are.
// A held result stalls req_ only while rsp_stall is high.
module positional_ordered_list #(
   parameter int CAPACITY = posl_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  posl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output posl_pkg::rsp_type rsp_data
);
   import posl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_data_in;
   logic                     accept;
   logic [CMP_W-1:0]         pos_cmp;
   logic [CMP_W-1:0]         cnt_cmp;
   logic [CMP_W-1:0]         cnt_next_cmp;
   logic [1:0]               status;
   logic                     ins_ok;
   logic                     rem_ok;
   logic                     rd_ok;
   logic signed [DATA_W-1:0] rd_entry;
   cell_cmd_type             cmd;
   logic signed [DATA_W-1:0] cell_q [CAPACITY];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign pos_cmp   = CMP_W'(req_data.position);
   assign cnt_cmp   = CMP_W'(count_ff);

   always_comb begin
      status = STATUS_DONE;
      ins_ok = 1'b0;
      rem_ok = 1'b0;
      rd_ok  = 1'b0;
      unique case (req_data.func)
         FUNC_INSERT: begin
            if (pos_cmp > cnt_cmp) begin
               status = STATUS_RANGE;
            end else if (cnt_cmp == CAP_C) begin
               status = STATUS_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (pos_cmp >= cnt_cmp) begin
               status = STATUS_RANGE;
            end else begin
               rem_ok = 1'b1;
            end
         end
         FUNC_READ: begin
            if (pos_cmp >= cnt_cmp) begin
               status = STATUS_RANGE;
            end else begin
               rd_ok = 1'b1;
            end
         end
         default: begin
            status = STATUS_DONE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_data.func == FUNC_CLEAR) begin
            count_in = '0;
         end else if (ins_ok) begin
            count_in = count_ff + CNT_W'(1);
         end else if (rem_ok) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   assign cmd.ins   = accept & ins_ok;
   assign cmd.rem   = accept & rem_ok;
   assign cmd.pos   = req_data.position;
   assign cmd.value = req_data.value;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         posl_cell #(
            .IDX   (g),
            .CMP_W (CMP_W)
         ) u_cell (
            .clock   (clock),
            .cmd     (cmd),
            .left_q  ((g == 0) ? req_data.value : cell_q[(g == 0) ? 0 : g - 1]),
            .right_q ((g == CAPACITY - 1) ? cell_q[g]
                                          : cell_q[(g == CAPACITY - 1) ? g : g + 1]),
            .entry_q (cell_q[g])
         );
      end
   endgenerate

   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (pos_cmp == CMP_W'(i)) begin
            rd_entry = cell_q[i];
         end
      end
   end

   assign cnt_next_cmp = CMP_W'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = status;
         rsp_data_in.read_data = rd_ok ? rd_entry : '0;
         rsp_data_in.length    = cnt_next_cmp[LEN_W-1:0];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/posl_checker.sv
// Port-level checks for the positional ordered list, bound to the top level.
module posl_checker #(
   parameter int CAPACITY = posl_pkg::DEFAULT_CAPACITY
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input posl_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input posl_pkg::rsp_type rsp_data
);
   import posl_pkg::*;

   localparam logic [LEN_W:0] CAP_LIM = (CAPACITY > 31) ? {1'b0, {LEN_W{1'b1}}}
                                                        : (LEN_W + 1)'(CAPACITY);

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while result side is free");

   a_transfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no result");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.func == FUNC_CLEAR)
      |=> (rsp_data.length == '0 && rsp_data.status == STATUS_DONE))
      else $error("clear did not empty the list");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_DONE) |-> (rsp_data.read_data == '0))
      else $error("failed request returned nonzero data");

   a_length_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.length} <= CAP_LIM))
      else $error("length exceeds capacity");

endmodule

bind positional_ordered_list posl_checker #(.CAPACITY(CAPACITY)) u_posl_checker (.*);

### tb/sv/posl_list_checker.sv
// Result checker for the positional ordered list: predicts every response and compares it.
`timescale 1ns / 100ps

module posl_list_checker #(
   parameter int CAPACITY = posl_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  posl_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  posl_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                outstanding
);
   import posl_pkg::*;

   logic signed [DATA_W-1:0] list_store [CAPACITY];
   int                       list_len;
   rsp_type                  pending_results [$];
   int                       fail_total;

   // Apply one request to the shadow list and return the response it must produce.
   function automatic rsp_type apply_list_op(req_type r);
      rsp_type res;
      int      i;
      res.status    = STATUS_DONE;
      res.read_data = '0;
      case (r.func)
         FUNC_INSERT: begin
            if (r.position > list_len) begin
               res.status = STATUS_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = list_len; i > r.position; i--)
                  list_store[i] = list_store[i-1];
               list_store[r.position] = r.value;
               list_len++;
            end
         end
         FUNC_REMOVE: begin
            if (r.position >= list_len) begin
               res.status = STATUS_RANGE;
            end else begin
               for (i = r.position; i + 1 < list_len; i++)
                  list_store[i] = list_store[i+1];
               list_len--;
            end
         end
         FUNC_READ: begin
            if (r.position >= list_len) begin
               res.status = STATUS_RANGE;
            end else begin
               res.read_data = list_store[r.position];
            end
         end
         default: begin
            list_len = 0;
         end
      endcase
      res.length = LEN_W'(list_len);
      return res;
   endfunction

   task automatic log_failure(string msg);
      fail_total++;
      if (fail_total <= 10)
         $display("%t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : track_channels
      rsp_type want;
      if (reset) begin
         list_len = 0;
         pending_results.delete();
      end else begin
         // Retire first: a result never belongs to the request taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               log_failure($sformatf("unexpected response: status %0d data %0d length %0d",
                                     rsp_data.status, rsp_data.read_data, rsp_data.length));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.read_data !== want.read_data ||
                   rsp_data.length !== want.length)
                  log_failure($sformatf({"response mismatch: expected status %0d data %0d ",
                                         "length %0d, got status %0d data %0d length %0d"},
                                        want.status, want.read_data, want.length,
                                        rsp_data.status, rsp_data.read_data,
                                        rsp_data.length));
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(apply_list_op(req_data));
      end
      fail_count  <= fail_total;
      outstanding <= pending_results.size();
   end

endmodule

### tb/sv/positional_ordered_list_tb.sv
// Testbench top for the positional ordered list: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module positional_ordered_list_tb;
   import posl_pkg::*;

   localparam int CAPACITY       = DEFAULT_CAPACITY;
   localparam int QUIET_LIMIT    = 5000;
   localparam int HOLD_OFF_CYCLES = 64;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int   hold_off_seq;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   list_len;
   int   quiet_cycles;
   int   fail_count;
   int   outstanding;

   positional_ordered_list #(.CAPACITY(CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   posl_list_checker #(.CAPACITY(CAPACITY)) list_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stall, or one long hold-off each time the stimulus asks for one.
   initial begin
      int hold_off_seen;
      hold_off_seen = 0;
      rsp_stall     = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_seq != hold_off_seen) begin
            hold_off_seen = hold_off_seq;
            rsp_stall     <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("positional_ordered_list verification failed");
            $finish;
         end
      end
   end

   // Offer one request, hold it until the transfer, and track the list length.
   task automatic offer_request(input logic [1:0] f, input int pos, input logic [31:0] v);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data.func     <= f;
      req_data.position <= POS_W'(pos);
      req_data.value    <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (f)
         FUNC_INSERT: if (pos <= list_len && list_len < CAPACITY) list_len++;
         FUNC_REMOVE: if (pos < list_len) list_len--;
         FUNC_CLEAR:  list_len = 0;
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [31:0] pick_value();
      if ($urandom_range(99) < 10) begin
         case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // Bursts that mostly grow or mostly shrink the list, so it swings between empty and full.
   task automatic run_random(input int n_items);
      int         k;
      int         burst_left;
      bit         growing;
      int         roll;
      int         pos;
      logic [1:0] f;
      burst_left = 0;
      growing    = 1'b1;
      for (k = 0; k < n_items; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(30, 5);
            growing    = (list_len < 8) ? ($urandom_range(99) < 80) : ($urandom_range(99) < 40);
         end
         burst_left--;
         roll = $urandom_range(99);
         if (roll < 3)
            f = FUNC_CLEAR;
         else if (roll < 23)
            f = FUNC_READ;
         else if (growing)
            f = (roll < 83) ? FUNC_INSERT : FUNC_REMOVE;
         else
            f = (roll < 83) ? FUNC_REMOVE : FUNC_INSERT;
         if ($urandom_range(99) < 10)
            pos = $urandom_range(31);
         else if (f == FUNC_INSERT)
            pos = $urandom_range(list_len);
         else
            pos = (list_len == 0) ? 0 : $urandom_range(list_len - 1);
         offer_request(f, pos, pick_value());
      end
   endtask

   initial begin
      int i;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      list_len    = 0;
      tx_idle_pct = 6;
      rx_idle_pct = 82;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of range on an empty list.
      offer_request(FUNC_READ, 0, $urandom);
      offer_request(FUNC_REMOVE, 0, $urandom);
      offer_request(FUNC_INSERT, 1, $urandom);
      // Fill to capacity at the head, the tail and the middle.
      for (i = 0; i < CAPACITY; i++) begin
         case (i % 3)
            0:       offer_request(FUNC_INSERT, 0, (i < 4) ? 32'h7FFF_FFFF : $urandom);
            1:       offer_request(FUNC_INSERT, list_len, (i < 4) ? 32'h8000_0000 : $urandom);
            default: offer_request(FUNC_INSERT, list_len / 2, (i < 4) ? 32'h0 : 32'hFFFF_FFFF);
         endcase
      end
      offer_request(FUNC_INSERT, 5, $urandom);
      // Past the end while full: the range check wins.
      offer_request(FUNC_INSERT, CAPACITY + 1, $urandom);
      offer_request(FUNC_READ, CAPACITY - 1, $urandom);
      offer_request(FUNC_READ, CAPACITY, $urandom);
      offer_request(FUNC_REMOVE, 31, $urandom);
      offer_request(FUNC_REMOVE, 0, $urandom);
      offer_request(FUNC_CLEAR, 0, $urandom);
      offer_request(FUNC_READ, 0, $urandom);

      run_random(190);
      drain_results();

      tx_idle_pct = 82;
      rx_idle_pct = 6;
      run_random(95);
      drain_results();
      run_random(95);
      drain_results();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_random(60);
      hold_off_seq++;
      run_random(130);

      drain_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("positional_ordered_list verification clean");
      end else begin
         $display("positional_ordered_list verification failed");
      end
      $finish;
   end

endmodule
